// ----- rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Code points and UTF-8 byte limits
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [7:0]  ASCII_MAX   = 8'h7F;
  localparam logic [7:0]  LEAD_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD_MAX    = 8'hF4;
  localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
  localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
  localparam logic [7:0]  CONT_LO     = 8'h80;
  localparam logic [7:0]  CONT_HI     = 8'hBF;
  localparam logic [6:0]  CONT_MASK   = 7'h3F;

  // Leads with a narrowed first continuation range
  localparam logic [7:0]  LEAD_E0     = 8'hE0;
  localparam logic [7:0]  LEAD_ED     = 8'hED;
  localparam logic [7:0]  LEAD_F0     = 8'hF0;
  localparam logic [7:0]  LEAD_F4     = 8'hF4;
  localparam logic [7:0]  E0_LO       = 8'hA0;
  localparam logic [7:0]  ED_HI       = 8'h9F;
  localparam logic [7:0]  F0_LO       = 8'h90;
  localparam logic [7:0]  F4_HI       = 8'h8F;

  // Surrogate encoding
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  // Queue between the decode front and the emit back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One decoded byte: one or two code units
  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic        rep0;
    logic [15:0] unit1;
    logic        rep1;
  } job_t;

endpackage

// ----- rtl/utf8_to_utf16_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// UTF-8 byte stream in, UTF-16 code units out, with U+FFFD for malformed input.
// ----------------------------------------------------------------------------
// A byte's job enters the job queue at the edge that accepts the byte; the
// back loads its units in order into the output register. Throughput: one
// byte per cycle unless the queue is full; the output register moves one
// unit per cycle when not stalled, so a byte giving two units occupies it twice.
// A four-entry job queue between decode and output absorbs those bursts.
// Reset clears the pending sequence, the queue and the output valid.
module utf8_to_utf16_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        unit_valid,
  input  logic        unit_stall,
  output logic [15:0] code_unit,
  output logic        is_replacement,
  output logic        last_of_run
);

  u8u16_pkg::job_t push_job;
  u8u16_pkg::job_t head_job;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;

  // Decode front
  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  // Job queue
  u8u16_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Emit back
  u8u16_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .unit_valid     (unit_valid),
    .unit_stall     (unit_stall),
    .code_unit      (code_unit),
    .is_replacement (is_replacement),
    .last_of_run    (last_of_run)
  );

endmodule

// ----- rtl/u8u16_front.sv -----
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, tracks the pending sequence and produces decoded jobs.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        in_byte,
  input  logic              end_of_string,
  input  logic              q_full,
  output logic              q_push,
  output u8u16_pkg::job_t   q_job
);

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        rep;
    logic        open;
    logic [1:0]  remaining;
    logic [20:0] point;
  } lead_res_t;

  logic [1:0]  bytes_remaining;
  logic        first_cont_expected;
  logic [7:0]  lead_value;
  logic [20:0] partial_point;

  logic [1:0]  bytes_remaining_next;
  logic        first_cont_expected_next;
  logic [7:0]  lead_value_next;
  logic [20:0] partial_point_next;

  logic        accept;
  logic [1:0]  n_units;
  lead_res_t   lr;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic        bad_cont;
  logic [20:0] joined;
  logic [20:0] offset;

  // Classify a byte seen as the start of a character
  function automatic lead_res_t lead_decode(input logic [7:0] b);
    lead_res_t r;
    r = '0;
    if (b <= u8u16_pkg::ASCII_MAX) begin
      r.emit = 1'b1;
      r.unit = {8'h00, b};
    end else if (b < u8u16_pkg::LEAD_MIN || b > u8u16_pkg::LEAD_MAX) begin
      r.emit = 1'b1;
      r.unit = u8u16_pkg::REPLACEMENT;
      r.rep  = 1'b1;
    end else begin
      r.open = 1'b1;
      if (b <= u8u16_pkg::LEAD2_MAX) begin
        r.remaining = 2'd1;
        r.point     = {16'h0000, b[4:0]};
      end else if (b <= u8u16_pkg::LEAD3_MAX) begin
        r.remaining = 2'd2;
        r.point     = {17'h00000, b[3:0]};
      end else begin
        r.remaining = 2'd3;
        r.point     = {18'h00000, b[2:0]};
      end
    end
    return r;
  endfunction

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign q_push     = accept && (n_units != 2'd0);

  // Range of the current continuation byte
  always_comb begin
    lo = u8u16_pkg::CONT_LO;
    hi = u8u16_pkg::CONT_HI;
    if (first_cont_expected) begin
      case (lead_value)
        u8u16_pkg::LEAD_E0: lo = u8u16_pkg::E0_LO;
        u8u16_pkg::LEAD_ED: hi = u8u16_pkg::ED_HI;
        u8u16_pkg::LEAD_F0: lo = u8u16_pkg::F0_LO;
        u8u16_pkg::LEAD_F4: hi = u8u16_pkg::F4_HI;
        default: ;
      endcase
    end
  end

  assign lr       = lead_decode(in_byte);
  assign bad_cont = (in_byte < lo) || (in_byte > hi);
  assign joined   = {partial_point[14:0], in_byte[5:0] & u8u16_pkg::CONT_MASK[5:0]};
  assign offset   = joined - u8u16_pkg::SUPP_BASE;

  // Decode the byte and advance the sequence state
  always_comb begin
    bytes_remaining_next     = bytes_remaining;
    first_cont_expected_next = first_cont_expected;
    lead_value_next          = lead_value;
    partial_point_next       = partial_point;
    n_units                  = 2'd0;
    q_job                    = '0;
    if (end_of_string) begin
      if (bytes_remaining != 2'd0) begin
        n_units     = 2'd1;
        q_job.unit0 = u8u16_pkg::REPLACEMENT;
        q_job.rep0  = 1'b1;
      end
      bytes_remaining_next     = 2'd0;
      first_cont_expected_next = 1'b0;
      lead_value_next          = 8'h00;
      partial_point_next       = '0;
    end else if (bytes_remaining == 2'd0) begin
      if (lr.emit) begin
        n_units     = 2'd1;
        q_job.unit0 = lr.unit;
        q_job.rep0  = lr.rep;
      end
      if (lr.open) begin
        bytes_remaining_next     = lr.remaining;
        first_cont_expected_next = 1'b1;
        lead_value_next          = in_byte;
        partial_point_next       = lr.point;
      end
    end else if (bad_cont) begin
      // Drop the sequence, then reuse the byte as a lead
      q_job.unit0              = u8u16_pkg::REPLACEMENT;
      q_job.rep0               = 1'b1;
      n_units                  = 2'd1;
      bytes_remaining_next     = 2'd0;
      first_cont_expected_next = 1'b0;
      lead_value_next          = 8'h00;
      partial_point_next       = '0;
      if (lr.emit) begin
        n_units     = 2'd2;
        q_job.pair  = 1'b1;
        q_job.unit1 = lr.unit;
        q_job.rep1  = lr.rep;
      end
      if (lr.open) begin
        bytes_remaining_next     = lr.remaining;
        first_cont_expected_next = 1'b1;
        lead_value_next          = in_byte;
        partial_point_next       = lr.point;
      end
    end else begin
      partial_point_next       = joined;
      first_cont_expected_next = 1'b0;
      bytes_remaining_next     = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        bytes_remaining_next = 2'd0;
        lead_value_next      = 8'h00;
        partial_point_next   = '0;
        if (joined < u8u16_pkg::SUPP_BASE) begin
          n_units     = 2'd1;
          q_job.unit0 = joined[15:0];
        end else begin
          n_units     = 2'd2;
          q_job.pair  = 1'b1;
          q_job.unit0 = u8u16_pkg::HI_SURR | {6'b000000, offset[19:10]};
          q_job.unit1 = u8u16_pkg::LO_SURR | {6'b000000, offset[9:0]};
        end
      end
    end
  end

  // Hold the sequence state between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining     <= 2'd0;
      first_cont_expected <= 1'b0;
      lead_value          <= 8'h00;
      partial_point       <= '0;
    end else if (accept) begin
      bytes_remaining     <= bytes_remaining_next;
      first_cont_expected <= first_cont_expected_next;
      lead_value          <= lead_value_next;
      partial_point       <= partial_point_next;
    end
  end

endmodule

// ----- rtl/u8u16_queue.sv -----
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue that decouples the decode front from the emit back.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::job_t   push_job,
  input  logic              pop,
  output u8u16_pkg::job_t   head_job,
  output logic              empty,
  output logic              full
);

  u8u16_pkg::job_t                   slots [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]      wr_ptr;
  logic [u8u16_pkg::QPTR_W-1:0]      rd_ptr;
  logic [u8u16_pkg::QCNT_W-1:0]      count;

  assign empty    = (count == '0);
  assign full     = (count == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
  assign head_job = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/u8u16_back.sv -----
// ----------------------------------------------------------------------------
// u8u16_back
// Splits queued jobs into single code units and holds them in an output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  u8u16_pkg::job_t   head_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              unit_valid,
  input  logic              unit_stall,
  output logic [15:0]       code_unit,
  output logic              is_replacement,
  output logic              last_of_run
);

  logic sel;
  logic sel_next;
  logic load;
  logic take;
  logic last_pick;

  // Pick the next unit of the head job
  always_comb begin
    load      = !unit_valid || !unit_stall;
    take      = load && !q_empty;
    last_pick = !head_job.pair || sel;
    q_pop     = take && last_pick;
    sel_next  = take ? !last_pick : sel;
  end

  // Control: output valid and unit select
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
      sel        <= 1'b0;
    end else begin
      if (load) begin
        unit_valid <= !q_empty;
      end
      sel <= sel_next;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (take) begin
      code_unit      <= sel ? head_job.unit1 : head_job.unit0;
      is_replacement <= sel ? head_job.rep1  : head_job.rep0;
      last_of_run    <= last_pick;
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_utf16_decoder_core. Drives directed and
// random UTF-8 byte streams through the valid/stall byte channel, predicts
// every UTF-16 code unit in a scoreboard and checks each unit in order.
// ----------------------------------------------------------------------------
import u8u16_pkg::*;

typedef struct {
  bit [15:0] unit;
  bit        rep;
  bit        last;
} exp_unit_t;

// Scoreboard: decoder prediction plus the queue of code units still due
class u16_unit_scoreboard;
  exp_unit_t expected_units[$];
  int        errors;
  int        bytes_noted;
  int        flushes_noted;
  int        units_checked;
  int        replacements;
  int        pairs;

  // Pending multibyte sequence
  bit [1:0]  remaining;
  bit        first_cont;
  bit [7:0]  lead;
  bit [20:0] point;

  function new();
    clear_seq();
    errors = 0;
    bytes_noted = 0;
    flushes_noted = 0;
    units_checked = 0;
    replacements = 0;
    pairs = 0;
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void clear_seq();
    remaining = 2'd0;
    first_cont = 1'b0;
    lead = 8'h00;
    point = 21'h0;
  endfunction

  function void emit(bit [15:0] u, bit rep);
    exp_unit_t e;
    e.unit = u;
    e.rep = rep;
    e.last = 1'b0;
    expected_units.push_back(e);
    if (rep) replacements++;
  endfunction

  // Emit a code point as one unit or a surrogate pair
  function void emit_point(bit [20:0] cp);
    bit [20:0] v;
    if (cp < SUPP_BASE) begin
      emit(cp[15:0], 1'b0);
    end else begin
      v = cp - SUPP_BASE;
      emit(HI_SURR | {6'd0, v[19:10]}, 1'b0);
      emit(LO_SURR | {6'd0, v[9:0]}, 1'b0);
      pairs++;
    end
  endfunction

  function void take_lead(bit [7:0] b);
    if (b <= ASCII_MAX) begin
      emit({8'h00, b}, 1'b0);
    end else if (b < LEAD_MIN || b > LEAD_MAX) begin
      emit(REPLACEMENT, 1'b1);
    end else begin
      if (b <= LEAD2_MAX) begin
        remaining = 2'd1;
        point = {16'd0, b[4:0]};
      end else if (b <= LEAD3_MAX) begin
        remaining = 2'd2;
        point = {17'd0, b[3:0]};
      end else begin
        remaining = 2'd3;
        point = {18'd0, b[2:0]};
      end
      first_cont = 1'b1;
      lead = b;
    end
  endfunction

  function void take_cont(bit [7:0] b);
    bit [7:0]  lo;
    bit [7:0]  hi;
    bit [20:0] cp;
    lo = CONT_LO;
    hi = CONT_HI;
    // Narrow the first continuation range for the overlong, surrogate and F4 leads
    if (first_cont) begin
      case (lead)
        LEAD_E0: lo = E0_LO;
        LEAD_ED: hi = ED_HI;
        LEAD_F0: lo = F0_LO;
        LEAD_F4: hi = F4_HI;
        default: ;
      endcase
    end
    if (b < lo || b > hi) begin
      // Drop the sequence, then retry the byte as a lead
      emit(REPLACEMENT, 1'b1);
      clear_seq();
      take_lead(b);
    end else begin
      point = {point[14:0], b[5:0]};
      first_cont = 1'b0;
      remaining = remaining - 2'd1;
      if (remaining == 2'd0) begin
        cp = point;
        clear_seq();
        emit_point(cp);
      end
    end
  endfunction

  // Note one accepted byte transaction and queue the units it causes
  function void note_byte(bit [7:0] b, bit flush);
    int        before_cnt;
    exp_unit_t e;
    before_cnt = expected_units.size();
    bytes_noted++;
    if (flush) begin
      flushes_noted++;
      if (remaining != 2'd0) emit(REPLACEMENT, 1'b1);
      clear_seq();
    end else if (remaining == 2'd0) begin
      take_lead(b);
    end else begin
      take_cont(b);
    end
    if (expected_units.size() > before_cnt) begin
      e = expected_units.pop_back();
      e.last = 1'b1;
      expected_units.push_back(e);
    end
  endfunction

  // Check one accepted unit transaction against the oldest expectation
  function void check_unit(logic [15:0] cu, logic rep, logic last);
    exp_unit_t want;
    units_checked++;
    if (expected_units.size() == 0) begin
      report($sformatf("unit %h arrived with nothing expected", cu));
      return;
    end
    want = expected_units.pop_front();
    if (cu !== want.unit)
      report($sformatf("code_unit got %h, expected %h", cu, want.unit));
    if (rep !== want.rep)
      report($sformatf("is_replacement got %b, expected %b (unit %h)", rep, want.rep,
                       want.unit));
    if (last !== want.last)
      report($sformatf("last_of_run got %b, expected %b (unit %h)", last, want.last,
                       want.unit));
  endfunction
endclass

module tb;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_MAX = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {
    CHUNK_POINT,
    CHUNK_NOISE,
    CHUNK_TRUNC,
    CHUNK_BADCONT,
    CHUNK_FLUSH
  } chunk_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  in_byte;
  logic        end_of_string;
  logic        unit_valid;
  logic        unit_stall;
  logic [15:0] code_unit;
  logic        is_replacement;
  logic        last_of_run;

  u16_unit_scoreboard sb;

  // {end_of_string, in_byte} items waiting to be sent
  bit [8:0] burst[$];
  int       items_sent = 0;
  int       fast_left = 0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;
  bit       no_stall = 1'b0;

  utf8_to_utf16_decoder_core dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .unit_valid     (unit_valid),
    .unit_stall     (unit_stall),
    .code_unit      (code_unit),
    .is_replacement (is_replacement),
    .last_of_run    (last_of_run)
  );

  always #2 clk = ~clk;

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Code point over all UTF-8 lengths, with a share of range boundaries
  function automatic bit [20:0] pick_point();
    bit [20:0] cp;
    bit [20:0] marks[11] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                             21'hE000, 21'hFFFD, 21'hFFFF, 21'h10000, 21'h10FFFF};
    if ($urandom_range(0, 9) == 0) return marks[$urandom_range(0, 10)];
    case ($urandom_range(1, 4))
      1: cp = $urandom_range(0, 'h7F);
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        cp = $urandom_range('h800, 'hFFFF);
        // Move surrogate values back into the plain three-byte range
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h8000;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  task automatic push_point(bit [20:0] cp);
    if (cp < 'h80) begin
      burst.push_back({1'b0, cp[7:0]});
    end else if (cp < 'h800) begin
      burst.push_back({1'b0, 3'b110, cp[10:6]});
      burst.push_back({1'b0, 2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      burst.push_back({1'b0, 4'b1110, cp[15:12]});
      burst.push_back({1'b0, 2'b10, cp[11:6]});
      burst.push_back({1'b0, 2'b10, cp[5:0]});
    end else begin
      burst.push_back({1'b0, 5'b11110, cp[20:18]});
      burst.push_back({1'b0, 2'b10, cp[17:12]});
      burst.push_back({1'b0, 2'b10, cp[11:6]});
      burst.push_back({1'b0, 2'b10, cp[5:0]});
    end
  endtask

  // Build one random chunk: mostly well-formed characters, some broken input
  task automatic build_chunk();
    chunk_kind_t kind;
    int          r;
    int          keep;
    bit [20:0]   cp;
    bit [7:0]    b;
    bit [7:0]    lead_b;
    bit [7:0]    boundary_bytes[8] = '{8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0,
                                       8'hBF, 8'hC0};
    r = $urandom_range(0, 99);
    kind = r < 60 ? CHUNK_POINT : r < 70 ? CHUNK_NOISE : r < 80 ? CHUNK_TRUNC :
           r < 92 ? CHUNK_BADCONT : CHUNK_FLUSH;
    case (kind)
      CHUNK_POINT: push_point(pick_point());
      CHUNK_NOISE: begin
        b = $urandom_range(0, 255);
        burst.push_back({1'b0, b});
      end
      CHUNK_TRUNC: begin
        // Cut a multibyte character short, sometimes ending the string there
        cp = pick_point();
        if (cp < 'h80) cp = cp | 21'h80;
        push_point(cp);
        keep = $urandom_range(1, burst.size() - 1);
        while (burst.size() > keep) void'(burst.pop_back());
        if ($urandom_range(0, 1) == 1) begin
          b = $urandom_range(0, 255);
          burst.push_back({1'b1, b});
        end
      end
      CHUNK_BADCONT: begin
        case ($urandom_range(0, 4))
          0: lead_b = LEAD_E0;
          1: lead_b = LEAD_ED;
          2: lead_b = LEAD_F0;
          3: lead_b = LEAD_F4;
          default: lead_b = $urandom_range(LEAD_MIN, LEAD_MAX);
        endcase
        if ($urandom_range(0, 2) == 0) b = $urandom_range(0, 255);
        else b = boundary_bytes[$urandom_range(0, 7)];
        burst.push_back({1'b0, lead_b});
        burst.push_back({1'b0, b});
        repeat ($urandom_range(0, 2)) begin
          b = $urandom_range(CONT_LO, CONT_HI);
          burst.push_back({1'b0, b});
        end
      end
      default: begin
        b = $urandom_range(0, 255);
        burst.push_back({1'b1, b});
      end
    endcase
  endtask

  // Offer one byte transaction and hold it until accepted
  task automatic send_item(bit [7:0] b, bit flush);
    @(negedge clk);
    byte_valid <= 1'b1;
    in_byte <= b;
    end_of_string <= flush;
    do @(posedge clk); while (byte_stall);
    items_sent++;
  endtask

  task automatic idle_bytes(int n);
    if (n > 0) begin
      @(negedge clk);
      byte_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_burst();
    foreach (burst[i]) begin
      send_item(burst[i][7:0], burst[i][8]);
      if (fast_left > 0) fast_left--;
      else idle_bytes(pick_gap());
    end
    burst.delete();
  endtask

  // Hold the byte side idle until every expected unit has come out
  task automatic wait_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.expected_units.size() != 0) @(posedge clk);
  endtask

  // Sample both channels at the rising edge; watch for a stuck run
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(in_byte, end_of_string);
      if (unit_valid && !unit_stall) sb.check_unit(code_unit, is_replacement, last_of_run);
      if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Unit receiver: random stalls, one long hold-off, and stall-free stretches
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    unit_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        unit_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        unit_stall <= 1'b0;
      end else if (no_stall) begin
        unit_stall <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          unit_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
        unit_stall <= 1'b0;
      end
    end
  end

  initial begin
    int  base;
    bit  hold_done;
    bit  drain_done;
    bit  quiet_done;
    rst = 1'b1;
    byte_valid = 1'b0;
    in_byte = 8'h00;
    end_of_string = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    quiet_done = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ASCII limits, bad leads, each length at a limit, the
    // narrowed first continuations, a proper U+FFFD, retried bytes, flushes
    burst = '{9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0C1, 9'h0F5,
              9'h0C2, 9'h080,
              9'h0E0, 9'h0A0, 9'h080,
              9'h0ED, 9'h09F, 9'h0BF,
              9'h0EF, 9'h0BF, 9'h0BD,
              9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
              9'h0E0, 9'h09F,
              9'h0F4, 9'h090,
              9'h0E2, 9'h000,
              9'h0F0, 9'h090, 9'h100,
              9'h1FF};
    send_burst();
    base = items_sent;

    // Random stream with pressure points along the way
    while (items_sent - base < RANDOM_ITEMS) begin
      build_chunk();
      if (!hold_done && items_sent - base >= 400) begin
        hold_done = 1'b1;
        hold_off = 1'b1;
        fast_left = 40;
      end
      if (!drain_done && items_sent - base >= 800) begin
        drain_done = 1'b1;
        wait_drained();
      end
      if (!quiet_done && items_sent - base >= 1100) begin
        quiet_done = 1'b1;
        no_stall = 1'b1;
        fast_left = 100;
      end
      if (no_stall && items_sent - base >= 1250) no_stall = 1'b0;
      send_burst();
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte transactions (%0d end-of-string flushes), %0d code units",
             sb.bytes_noted, sb.flushes_noted, sb.units_checked);
    $display("including %0d replacements and %0d surrogate pairs; %0d mismatches",
             sb.replacements, sb.pairs, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_decoder_core.sv
verif/tb.sv
